// File: hw/rtl/virtual_fat16_sector_generator_defines.svh
// -----------------------------------------------------------------------------
// Virtual FAT16 sector generator assertion macros
// Concurrent assertion helpers; they expand to nothing in synthesis.
// -----------------------------------------------------------------------------
`ifndef VIRTUAL_FAT16_SECTOR_GENERATOR_DEFINES_SVH
`define VIRTUAL_FAT16_SECTOR_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define VFSG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define VFSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define VFSG_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define VFSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: hw/rtl/vfsg_pkg.sv
// -----------------------------------------------------------------------------
// Virtual FAT16 sector generator package
// Widths, region codes, FAT entry codes, queue item type and FAT entry function.
// -----------------------------------------------------------------------------
package vfsg_pkg;

   localparam int FILE_CNT    = 8;
   localparam int SLOT_W      = 3;
   localparam int SIZE_W      = 16;
   localparam int TOTAL_W     = 19;
   localparam int CFG_W       = 4;
   localparam int SECTOR_W    = 32;
   localparam int REGION_W    = 3;
   localparam int ENTRY_W     = 16;
   localparam int FAT_IDX_W   = 11;
   localparam int GROUP_W     = 6;
   localparam int CLUSTER_W   = FAT_IDX_W + GROUP_W + 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int START_W     = 12;

   localparam logic [TOTAL_W-1:0] MIN_CLUSTERS = TOTAL_W'(32'h2000);
   localparam logic [ENTRY_W-1:0] ENTRY_MEDIA  = 16'hFFF8;
   localparam logic [ENTRY_W-1:0] ENTRY_EOC    = 16'hFFFF;
   localparam logic [ENTRY_W-1:0] ENTRY_PAD    = 16'hFFF7;
   localparam logic [GROUP_W-1:0] LAST_GROUP   = '1;

   typedef enum logic [REGION_W-1:0] {
      REGION_BOOT = 3'd0,
      REGION_FAT  = 3'd1,
      REGION_ROOT = 3'd2,
      REGION_DATA = 3'd3,
      REGION_LOAD = 3'd4
   } region_type;

   typedef logic [FILE_CNT-1:0][TOTAL_W-1:0] prefix_type;

   typedef struct packed {
      region_type           region;
      logic [FAT_IDX_W-1:0] fat_idx;
      logic                 hit;
      logic [SLOT_W-1:0]    idx;
      logic [SIZE_W-1:0]    offset;
   } job_type;

   // prefix[k] is the end sector of file k, counted from the data start
   function automatic logic [ENTRY_W-1:0] fat_entry(input logic [CLUSTER_W-1:0] c,
                                                    input logic [TOTAL_W-1:0] total,
                                                    input prefix_type prefix);
      logic [CLUSTER_W-1:0] s;
      logic [CLUSTER_W-1:0] c_next;
      logic                 eoc;
      logic [ENTRY_W-1:0]   e;
      s      = c - CLUSTER_W'(2);
      c_next = c + CLUSTER_W'(1);
      eoc    = 1'b0;
      for (int k = 0; k < FILE_CNT; k++) begin
         if (CLUSTER_W'(prefix[k]) == s) eoc = 1'b1;
      end
      if (c == CLUSTER_W'(0)) e = ENTRY_MEDIA;
      else if (c == CLUSTER_W'(1)) e = ENTRY_EOC;
      else if (c == CLUSTER_W'(2)) e = '0;
      else if (s > CLUSTER_W'(total)) e = ENTRY_PAD;
      else if (eoc) e = ENTRY_EOC;
      else e = c_next[ENTRY_W-1:0];
      return e;
   endfunction

endpackage

// File: hw/rtl/vfsg_queue.sv
// -----------------------------------------------------------------------------
// Job queue
// Short FIFO between the classifier and the result sequencer.
// -----------------------------------------------------------------------------
module vfsg_queue
   import vfsg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push_valid && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + (QPTR_W+1)'(1);
      else if (do_pop && !do_push) count_in = count_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// File: hw/rtl/vfsg_front.sv
// -----------------------------------------------------------------------------
// Request classifier
// Holds the file table and its end-sector sums, accepts items, maps a sector
// to its region and file, and queues one job per item.
// -----------------------------------------------------------------------------
module vfsg_front
   import vfsg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic [SLOT_W-1:0]   req_file_slot,
   input  logic [SIZE_W-1:0]   req_file_sectors,
   input  logic                csr_write_enable,
   input  logic [CFG_W-1:0]    csr_write_data,
   output logic                push_valid,
   output job_type             push_job,
   input  logic                queue_full,
   input  logic                queue_empty,
   input  logic                back_busy,
   output prefix_type          prefix,
   output logic [TOTAL_W-1:0]  total
);

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_CALC,
      FRONT_SEARCH
   } front_state_type;

   front_state_type              state_ff, state_in;
   logic [CFG_W-1:0]             files_ff;
   logic [FILE_CNT-1:0][SIZE_W-1:0] table_ff;
   prefix_type                   prefix_ff, prefix_in;
   logic                         kind_ff, kind_in;
   logic [SECTOR_W-1:0]          sector_ff, sector_in;
   logic [SLOT_W-1:0]            slot_ff, slot_in;
   logic [SIZE_W-1:0]            size_ff, size_in;
   region_type                   region_ff, region_in;
   logic [SECTOR_W-1:0]          rel_ff, rel_in;
   logic [FAT_IDX_W-1:0]         fat_idx_ff, fat_idx_in;

   logic [CFG_W-1:0]             used_n;
   logic [TOTAL_W-1:0]           acc;
   logic [TOTAL_W-1:0]           min_total;
   logic [TOTAL_W:0]             round_up;
   logic [START_W-1:0]           root_start;
   logic [START_W-1:0]           data_start;
   logic [SECTOR_W-1:0]          sector_less;
   prefix_type                   lower;
   logic                         hit;
   logic [SLOT_W-1:0]            hit_idx;
   logic [TOTAL_W-1:0]           hit_base;
   logic [SECTOR_W-1:0]          offset_full;
   logic                         drained;
   logic                         table_we;

   assign used_n = (files_ff > CFG_W'(FILE_CNT)) ? CFG_W'(FILE_CNT) : files_ff;
   assign prefix = prefix_ff;
   assign total  = prefix_ff[FILE_CNT-1];

   always_comb begin
      acc = '0;
      for (int i = 0; i < FILE_CNT; i++) begin
         if (CFG_W'(i) < used_n) acc = acc + TOTAL_W'(table_ff[i]);
         prefix_in[i] = acc;
      end
   end

   // layout of the current image
   always_comb begin
      min_total   = (total < MIN_CLUSTERS) ? MIN_CLUSTERS : total;
      round_up    = {1'b0, min_total} + (TOTAL_W+1)'(255);
      root_start  = START_W'(1) + START_W'(round_up[TOTAL_W:8]);
      data_start  = root_start + START_W'(used_n != '0);
      sector_less = sector_ff - SECTOR_W'(1);
   end

   always_comb begin
      lower[0] = '0;
      for (int i = 1; i < FILE_CNT; i++) lower[i] = prefix_ff[i-1];
      hit      = 1'b0;
      hit_idx  = '0;
      hit_base = '0;
      for (int i = 0; i < FILE_CNT; i++) begin
         if (!hit && rel_ff > SECTOR_W'(lower[i]) && rel_ff <= SECTOR_W'(prefix_ff[i])) begin
            hit      = 1'b1;
            hit_idx  = SLOT_W'(i);
            hit_base = lower[i];
         end
      end
      offset_full = rel_ff - SECTOR_W'(hit_base) - SECTOR_W'(1);
   end

   assign drained = queue_empty && !back_busy;

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      sector_in  = sector_ff;
      slot_in    = slot_ff;
      size_in    = size_ff;
      region_in  = region_ff;
      rel_in     = rel_ff;
      fat_idx_in = fat_idx_ff;
      push_valid = 1'b0;
      push_job   = '0;
      table_we   = 1'b0;
      unique case (state_ff)
         FRONT_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               sector_in = req_sector;
               slot_in   = req_file_slot;
               size_in   = req_file_sectors;
               state_in  = FRONT_CALC;
            end
         end
         FRONT_CALC: begin
            if (!kind_ff) begin
               if (drained) begin
                  table_we        = (int'(slot_ff) < FILE_CNT);
                  push_valid      = 1'b1;
                  push_job.region = REGION_LOAD;
                  state_in        = FRONT_IDLE;
               end
            end else begin
               fat_idx_in = sector_less[FAT_IDX_W-1:0];
               rel_in     = sector_ff - SECTOR_W'(data_start);
               if (sector_ff == '0) region_in = REGION_BOOT;
               else if (sector_ff < SECTOR_W'(root_start)) region_in = REGION_FAT;
               else if (sector_ff < SECTOR_W'(data_start)) region_in = REGION_ROOT;
               else region_in = REGION_DATA;
               state_in = FRONT_SEARCH;
            end
         end
         FRONT_SEARCH: begin
            if (!queue_full) begin
               push_valid       = 1'b1;
               push_job.region  = region_ff;
               push_job.fat_idx = fat_idx_ff;
               if (region_ff == REGION_DATA && hit) begin
                  push_job.hit    = 1'b1;
                  push_job.idx    = hit_idx;
                  push_job.offset = offset_full[SIZE_W-1:0];
               end
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   assign req_ready = (state_ff == FRONT_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff    <= kind_in;
      sector_ff  <= sector_in;
      slot_ff    <= slot_in;
      size_ff    <= size_in;
      region_ff  <= region_in;
      rel_ff     <= rel_in;
      fat_idx_ff <= fat_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         files_ff  <= '0;
         table_ff  <= '0;
         prefix_ff <= '0;
      end else begin
         if (csr_write_enable) files_ff <= csr_write_data;
         if (table_we) table_ff[slot_ff] <= size_ff;
         prefix_ff <= prefix_in;
      end
   end

endmodule

// File: hw/rtl/vfsg_back.sv
// -----------------------------------------------------------------------------
// Result sequencer
// Takes queued jobs and drives the result register; a FAT job walks 64 groups
// of four entries.
// -----------------------------------------------------------------------------
module vfsg_back
   import vfsg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  job_type             pop_job,
   input  logic                queue_empty,
   output logic                pop,
   output logic                busy,
   input  prefix_type          prefix,
   input  logic [TOTAL_W-1:0]  total,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [REGION_W-1:0] rsp_region,
   output logic [ENTRY_W-1:0]  rsp_entry_a,
   output logic [ENTRY_W-1:0]  rsp_entry_b,
   output logic [ENTRY_W-1:0]  rsp_entry_c,
   output logic [ENTRY_W-1:0]  rsp_entry_d,
   output logic                rsp_file_hit,
   output logic [SLOT_W-1:0]   rsp_file_index,
   output logic [SIZE_W-1:0]   rsp_file_offset,
   output logic                rsp_last
);

   logic                 busy_ff;
   job_type              job_ff;
   logic [GROUP_W-1:0]   group_ff;
   logic                 valid_ff;
   logic [REGION_W-1:0]  region_ff;
   logic [3:0][ENTRY_W-1:0] entry_ff, entry_in;
   logic                 hit_ff;
   logic [SLOT_W-1:0]    idx_ff;
   logic [SIZE_W-1:0]    offset_ff;
   logic                 last_ff, last_in;
   logic                 out_free;
   logic                 emit;
   logic                 is_fat;

   assign out_free = !valid_ff || rsp_ready;
   assign pop      = !busy_ff && !queue_empty;
   assign emit     = busy_ff && out_free;
   assign is_fat   = (job_ff.region == REGION_FAT);
   assign busy     = busy_ff;

   always_comb begin
      entry_in = '0;
      last_in  = 1'b1;
      if (is_fat) begin
         for (int j = 0; j < 4; j++) begin
            entry_in[j] = fat_entry({job_ff.fat_idx, group_ff, 2'(j)}, total, prefix);
         end
         last_in = (group_ff == LAST_GROUP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            busy_ff <= 1'b1;
         end else if (emit && last_in) begin
            busy_ff <= 1'b0;
         end
         if (emit) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff   <= pop_job;
         group_ff <= '0;
      end else if (emit) begin
         group_ff <= group_ff + GROUP_W'(1);
      end
      if (emit) begin
         region_ff <= job_ff.region;
         entry_ff  <= entry_in;
         hit_ff    <= job_ff.hit;
         idx_ff    <= job_ff.idx;
         offset_ff <= job_ff.offset;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_region      = region_ff;
   assign rsp_entry_a     = entry_ff[0];
   assign rsp_entry_b     = entry_ff[1];
   assign rsp_entry_c     = entry_ff[2];
   assign rsp_entry_d     = entry_ff[3];
   assign rsp_file_hit    = hit_ff;
   assign rsp_file_index  = idx_ff;
   assign rsp_file_offset = offset_ff;
   assign rsp_last        = last_ff;

endmodule

// File: hw/rtl/virtual_fat16_sector_generator.sv
// -----------------------------------------------------------------------------
// Virtual FAT16 sector generator
// Answers sector reads of a FAT16 image built from a table of file sizes.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: kind 0 loads req_file_sectors into slot
//   req_file_slot, kind 1 reads sector req_sector. csr_write_data sets the
//   number of file slots in the image; write it only while the block is idle.
//   rsp_* returns the results; rsp_last marks the final one of an item.
// Flow and throughput:
//   For each read item the classifier steps through accept, decode and file
//   search, then queues a job; the sequencer pops it into its job register
//   and then registers the first result. A FAT sector yields 64 results, one
//   per cycle while rsp_ready is high; the next job is fetched only after the
//   walk, which sets the sustained rate. Other reads give one result each.
//   A load waits until the queue and sequencer are empty, then takes effect
//   and returns one load-done result.
// Reset: clears the file table, the slot count and all handshake state.
// Stall: while rsp_ready is low the result register holds; the two-entry
//   queue keeps the classifier accepting until it fills.
// -----------------------------------------------------------------------------
`include "virtual_fat16_sector_generator_defines.svh"

module virtual_fat16_sector_generator
   import vfsg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic [SLOT_W-1:0]   req_file_slot,
   input  logic [SIZE_W-1:0]   req_file_sectors,
   input  logic                csr_write_enable,
   input  logic [CFG_W-1:0]    csr_write_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [REGION_W-1:0] rsp_region,
   output logic [ENTRY_W-1:0]  rsp_entry_a,
   output logic [ENTRY_W-1:0]  rsp_entry_b,
   output logic [ENTRY_W-1:0]  rsp_entry_c,
   output logic [ENTRY_W-1:0]  rsp_entry_d,
   output logic                rsp_file_hit,
   output logic [SLOT_W-1:0]   rsp_file_index,
   output logic [SIZE_W-1:0]   rsp_file_offset,
   output logic                rsp_last
);

   logic               push_valid;
   job_type            push_job;
   logic               queue_full;
   logic               queue_empty;
   logic               pop;
   job_type            pop_job;
   logic               back_busy;
   prefix_type         prefix;
   logic [TOTAL_W-1:0] total;

   vfsg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_sector       (req_sector),
      .req_file_slot    (req_file_slot),
      .req_file_sectors (req_file_sectors),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_job         (push_job),
      .queue_full       (queue_full),
      .queue_empty      (queue_empty),
      .back_busy        (back_busy),
      .prefix           (prefix),
      .total            (total)
   );

   vfsg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .pop_job    (pop_job),
      .empty      (queue_empty)
   );

   vfsg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_job         (pop_job),
      .queue_empty     (queue_empty),
      .pop             (pop),
      .busy            (back_busy),
      .prefix          (prefix),
      .total           (total),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_region      (rsp_region),
      .rsp_entry_a     (rsp_entry_a),
      .rsp_entry_b     (rsp_entry_b),
      .rsp_entry_c     (rsp_entry_c),
      .rsp_entry_d     (rsp_entry_d),
      .rsp_file_hit    (rsp_file_hit),
      .rsp_file_index  (rsp_file_index),
      .rsp_file_offset (rsp_file_offset),
      .rsp_last        (rsp_last)
   );

   `VFSG_ASSERT_IMPLY(a_push_not_full, clock, reset, push_valid, !queue_full, "push into full queue")
   `VFSG_ASSERT_IMPLY(a_single_last, clock, reset, rsp_valid && rsp_region != REGION_FAT, rsp_last, "single result without last")
   `VFSG_ASSERT_IMPLY(a_hit_only_data, clock, reset, rsp_valid && rsp_region != REGION_DATA, !rsp_file_hit && rsp_file_offset == '0, "file fields outside data region")
   `VFSG_ASSERT_NEXT(a_fat_burst, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid && rsp_region == REGION_FAT, "gap inside FAT burst")

endmodule
